@@ hw/rtl/three_marker_stream_deframer_defines.svh @@
// Assertion macros shared by the deframer checker.
`ifndef THREE_MARKER_STREAM_DEFRAMER_DEFINES_SVH
`define THREE_MARKER_STREAM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TMSD_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define TMSD_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset.
`define TMSD_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tmsd_pkg.sv @@
// Types, constants and helper functions of the three-marker deframer.
package tmsd_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_END      = 3'd1,
    KIND_EXPECT   = 3'd2,
    KIND_EXIT     = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_CLOSED   = 3'd5
  } kind_t;

  // Held marker prefix
  typedef enum logic [2:0] {
    M_NONE  = 3'd0,
    M_E     = 3'd1,
    M_EN    = 3'd2,
    M_EX    = 3'd3,
    M_EXP   = 3'd4,
    M_EXPE  = 3'd5,
    M_EXPEC = 3'd6,
    M_EXI   = 3'd7
  } match_t;

  // Marker characters
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_X = 8'h58;

  // Configuration register indexes
  localparam logic REG_PAYLOAD_LIMIT = 1'b0;
  localparam logic REG_HOLD_LIMIT    = 1'b1;

  // Op queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One classified item: a terminal event, or a run of n payload bytes
  // taken from the old held prefix followed by the new byte.
  typedef struct packed {
    kind_t       kind;
    match_t      st;
    logic [7:0]  data;
    logic [2:0]  n;
  } op_t;

  // Length of a held prefix
  function automatic logic [2:0] pfx_len(match_t st);
    logic [2:0] r;
    unique case (st)
      M_NONE:  r = 3'd0;
      M_E:     r = 3'd1;
      M_EN:    r = 3'd2;
      M_EX:    r = 3'd2;
      M_EXP:   r = 3'd3;
      M_EXPE:  r = 3'd4;
      M_EXPEC: r = 3'd5;
      M_EXI:   r = 3'd3;
    endcase
    return r;
  endfunction

  // Byte i of held prefix followed by byte b
  function automatic logic [7:0] seq_byte(match_t st, logic [7:0] b, logic [2:0] i);
    logic [7:0] r;
    if (i >= pfx_len(st)) begin
      r = b;
    end else begin
      unique case (i)
        3'd0:    r = CH_E;
        3'd1:    r = (st == M_EN) ? CH_N : CH_X;
        3'd2:    r = (st == M_EXI) ? CH_I : CH_P;
        3'd3:    r = CH_E;
        3'd4:    r = CH_C;
        default: r = b;
      endcase
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/three_marker_stream_deframer.sv @@
// Path: an accepted byte enters the op queue; its results are expanded into the
// output register and popped from there. Throughput: one byte per cycle while not
// full; a byte that flushes held bytes gives one result per flushed byte (up to
// six), one per cycle from the single-result expander while the output is taken,
// with a four-op queue absorbing bursts. Results drain one per cycle while popped.
// Reset (rst, synchronous): clears held prefix, counts, queue and output.
module three_marker_stream_deframer
  import tmsd_pkg::*;
#(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        link_closed,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [2:0]  kind,
  output logic        last,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [12:0] wr_data
);

  localparam logic [11:0] PL_RESET = 12'((BUFFER_BYTES - 1) % 4096);
  localparam logic [12:0] HL_RESET = 13'((2 * BUFFER_BYTES > 8191) ? 8191 : 2 * BUFFER_BYTES);

  logic [11:0] payload_limit;
  logic [12:0] hold_limit;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  op_t   q_wdata;
  op_t   q_rdata;
  kind_t kind_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= PL_RESET;
      hold_limit    <= HL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PAYLOAD_LIMIT: payload_limit <= wr_data[11:0];
        REG_HOLD_LIMIT:    hold_limit    <= wr_data;
      endcase
    end
  end

  assign full = q_full;
  assign kind = kind_q;

  tmsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold_limit  (hold_limit),
    .push        (push),
    .data_byte   (data_byte),
    .link_closed (link_closed),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  tmsd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tmsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .payload_limit (payload_limit),
    .q_empty       (q_empty),
    .q_op          (q_rdata),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .kind          (kind_q),
    .last          (last)
  );

endmodule

@@ hw/rtl/tmsd_queue.sv @@
// Small op queue that decouples the classifier from the result expander.
module tmsd_queue
  import tmsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  wdata,
  output logic full,
  input  logic pop,
  output op_t  rdata,
  output logic empty
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tmsd_front.sv @@
// Front end: accepts bytes, tracks the held prefix and message length, issues ops.
module tmsd_front
  import tmsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] hold_limit,
  input  logic        push,
  input  logic [7:0]  data_byte,
  input  logic        link_closed,
  input  logic        q_full,
  output logic        q_push,
  output op_t         q_data
);

  match_t      match_state;
  match_t      match_state_next;
  logic [12:0] message_count;
  logic [12:0] message_count_next;

  logic        accept;
  logic [13:0] cnt;
  logic        over;
  logic        is_mark;
  kind_t       mark_kind;
  match_t      ext_state;
  logic [2:0]  n_flush;

  // Prefix left after appending b: extension, or the longest marker-prefix tail
  function automatic match_t step_state(match_t st, logic [7:0] b);
    match_t r;
    r = M_NONE;
    unique case (st)
      M_NONE, M_EN, M_EXP, M_EXPEC, M_EXI: begin
        if (b == CH_E) begin
          r = (st == M_EXP) ? M_EXPE : M_E;
        end
      end
      M_E: begin
        priority if (b == CH_N) r = M_EN;
        else if (b == CH_X) r = M_EX;
        else if (b == CH_E) r = M_E;
      end
      M_EX: begin
        priority if (b == CH_P) r = M_EXP;
        else if (b == CH_I) r = M_EXI;
        else if (b == CH_E) r = M_E;
      end
      M_EXPE: begin
        priority if (b == CH_C) r = M_EXPEC;
        else if (b == CH_N) r = M_EN;
        else if (b == CH_X) r = M_EX;
        else if (b == CH_E) r = M_E;
      end
    endcase
    return r;
  endfunction

  assign accept = push && !q_full;

  // Classification of the incoming byte
  always_comb begin
    cnt       = {1'b0, message_count} + 14'd1;
    over      = (cnt >= {1'b0, hold_limit});
    is_mark   = 1'b1;
    mark_kind = KIND_END;
    priority if (match_state == M_EN && data_byte == CH_D) begin
      mark_kind = KIND_END;
    end else if (match_state == M_EXPEC && data_byte == CH_T) begin
      mark_kind = KIND_EXPECT;
    end else if (match_state == M_EXI && data_byte == CH_T) begin
      mark_kind = KIND_EXIT;
    end else begin
      is_mark = 1'b0;
    end
    ext_state = step_state(match_state, data_byte);
    n_flush   = pfx_len(match_state) + 3'd1 - pfx_len(ext_state);
  end

  // Next state
  always_comb begin
    match_state_next   = match_state;
    message_count_next = message_count;
    if (accept) begin
      if (link_closed || over || is_mark) begin
        match_state_next   = M_NONE;
        message_count_next = '0;
      end else begin
        match_state_next   = ext_state;
        message_count_next = cnt[12:0];
      end
    end
  end

  // Op toward the back end
  always_comb begin
    q_data.st   = match_state;
    q_data.data = data_byte;
    q_data.n    = n_flush;
    priority if (link_closed) q_data.kind = KIND_CLOSED;
    else if (over) q_data.kind = KIND_OVERFLOW;
    else if (is_mark) q_data.kind = mark_kind;
    else q_data.kind = KIND_PAYLOAD;
    q_push = accept && (link_closed || over || is_mark || n_flush != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_state   <= M_NONE;
      message_count <= '0;
    end else begin
      match_state   <= match_state_next;
      message_count <= message_count_next;
    end
  end

endmodule

@@ hw/rtl/tmsd_back.sv @@
// Back end: expands ops into results, applies the payload limit, holds the output item.
module tmsd_back
  import tmsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] payload_limit,
  input  logic        q_empty,
  input  op_t         q_op,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte,
  output kind_t       kind,
  output logic        last
);

  logic [2:0]  idx;
  logic [11:0] payload_count;
  logic        out_valid;

  logic        slot;
  logic        is_pay;
  logic        room;
  logic [11:0] pc_inc;
  logic        op_end;
  logic        drop;
  logic        emit;

  assign empty = !out_valid;

  // Step decision for the op at the queue head
  always_comb begin
    slot   = !out_valid || pop;
    is_pay = (q_op.kind == KIND_PAYLOAD);
    room   = (payload_count < payload_limit);
    pc_inc = payload_count + 12'd1;
    op_end = (idx == q_op.n - 3'd1) || (pc_inc == payload_limit);
    drop   = !q_empty && is_pay && !room;
    emit   = !q_empty && (!is_pay || room) && slot;
    q_pop  = drop || (emit && (!is_pay || op_end));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= is_pay ? seq_byte(q_op.st, q_op.data, idx) : 8'd0;
      kind     <= q_op.kind;
      last     <= !is_pay || op_end;
    end
  end

  // Control: output valid, byte index within op, payload count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      idx           <= '0;
      payload_count <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (drop) begin
        idx <= '0;
      end else if (emit) begin
        idx           <= (is_pay && !op_end) ? idx + 3'd1 : 3'd0;
        payload_count <= is_pay ? pc_inc : 12'd0;
      end
    end
  end

endmodule

@@ hw/rtl/tmsd_checker.sv @@
// Port-level checks of the deframer and their bind to the top level.
`include "three_marker_stream_deframer_defines.svh"

module tmsd_checker
  import tmsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       last
);

  // Events carry no byte and always end their item's results
  `TMSD_HOLDS(a_event_shape, clk, rst, !empty && kind != KIND_PAYLOAD, out_byte == 8'd0 && last, "event item with byte or without last")

  // A flush run continues without a gap once its byte is taken
  `TMSD_NEXT(a_run_continues, clk, rst, !empty && pop && kind == KIND_PAYLOAD && !last, !empty && kind == KIND_PAYLOAD, "payload run broken before last")

  // A waiting result holds still
  `TMSD_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(out_byte) && $stable(kind) && $stable(last), "waiting result changed")

  // Reset leaves both sides idle
  `TMSD_AFTER_RESET(a_reset_idle, clk, rst, empty && !full, "not idle after reset")

endmodule

bind three_marker_stream_deframer tmsd_checker u_checker (.*);

@@ tb/deframer_checker.sv @@
// Checker for the three-marker deframer: predicts results from accepted items and compares.
module deframer_checker
  import tmsd_pkg::*;
#(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        link_closed,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic [2:0]  kind,
  input  logic        last,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [12:0] wr_data,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } deframe_result_t;

  // Results predicted but not yet popped, oldest first
  deframe_result_t results_due[$];

  // Shadow copy of the limits and the message state
  logic [11:0] payload_limit;
  logic [12:0] hold_limit;
  match_t      held;
  logic [12:0] msg_bytes;
  logic [11:0] payload_sent;

  initial errors = 0;
  initial pending = 0;

  // Marker text, left-aligned in 48 bits
  function automatic logic [7:0] word_char(kind_t k, int i);
    logic [47:0] w;
    case (k)
      KIND_END:  w = {"END", 24'h0};
      KIND_EXIT: w = {"EXIT", 16'h0};
      default:   w = "EXPECT";
    endcase
    return w[47 - 8 * i -: 8];
  endfunction

  function automatic int word_len(kind_t k);
    case (k)
      KIND_END:  return 3;
      KIND_EXIT: return 4;
      default:   return 6;
    endcase
  endfunction

  // Bytes held by each partial match
  function automatic int held_len(match_t m);
    case (m)
      M_E:               return 1;
      M_EN, M_EX:        return 2;
      M_EXP, M_EXI:      return 3;
      M_EXPE:            return 4;
      M_EXPEC:           return 5;
      default:           return 0;
    endcase
  endfunction

  // Marker that a partial match is the start of
  function automatic kind_t prefix_word(match_t m);
    case (m)
      M_EN:    return KIND_END;
      M_EXI:   return KIND_EXIT;
      default: return KIND_EXPECT;
    endcase
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic clear_message();
    held = M_NONE;
    msg_bytes = '0;
    payload_sent = '0;
  endtask

  task automatic predict_event(input kind_t k);
    deframe_result_t r;
    r.data = 8'h00;
    r.kind = k;
    r.last = 1'b1;
    results_due.push_back(r);
    clear_message();
  endtask

  // Work out the results of one accepted item
  task automatic deframe_byte(input logic [7:0] b, input logic closed);
    logic [7:0]      seq [6];
    logic [7:0]      flushed [6];
    int              len;
    int              keep;
    int              cnt;
    int              n;
    bit              hit;
    match_t          next;
    kind_t           mk;
    deframe_result_t r;

    if (closed) begin
      predict_event(KIND_CLOSED);
      return;
    end

    // overflow check comes before marker matching
    cnt = int'(msg_bytes) + 1;
    if (cnt >= int'(hold_limit)) begin
      predict_event(KIND_OVERFLOW);
      return;
    end
    msg_bytes = cnt[12:0];

    // held prefix followed by the new byte
    len = held_len(held);
    for (int i = 0; i < len; i++) seq[i] = word_char(prefix_word(held), i);
    seq[len] = b;
    len++;

    // complete marker
    for (int k = KIND_END; k <= KIND_EXIT; k++) begin
      mk = kind_t'(k);
      if (len == word_len(mk)) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++) if (seq[j] != word_char(mk, j)) hit = 1'b0;
        if (hit) begin
          predict_event(mk);
          return;
        end
      end
    end

    // longest tail that can still start a marker stays held
    keep = 0;
    next = M_NONE;
    for (int i = len; i > 0 && next == M_NONE; i--) begin
      for (int m = M_E; m <= M_EXI; m++) begin
        if (next == M_NONE && held_len(match_t'(m)) == i) begin
          hit = 1'b1;
          for (int j = 0; j < i; j++)
            if (seq[len - i + j] != word_char(prefix_word(match_t'(m)), j)) hit = 1'b0;
          if (hit) begin
            keep = i;
            next = match_t'(m);
          end
        end
      end
    end

    // flushed bytes go out as payload up to the limit
    n = 0;
    for (int i = 0; i < len - keep; i++) begin
      if (payload_sent < payload_limit) begin
        flushed[n] = seq[i];
        n++;
        payload_sent++;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.data = flushed[i];
      r.kind = KIND_PAYLOAD;
      r.last = (i == n - 1);
      results_due.push_back(r);
    end
    held = next;
  endtask

  // Watch all three ports at the rising edge
  always @(posedge clk) begin
    deframe_result_t want;
    if (rst) begin
      payload_limit = 12'((BUFFER_BYTES - 1) & 'hFFF);
      hold_limit = (2 * BUFFER_BYTES > 8191) ? 13'd8191 : 13'(2 * BUFFER_BYTES);
      clear_message();
      results_due.delete();
    end else begin
      if (wr_en) begin
        if (wr_index == REG_PAYLOAD_LIMIT) payload_limit = wr_data[11:0];
        else hold_limit = wr_data;
      end
      if (push && !full) deframe_byte(data_byte, link_closed);
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          report($sformatf("result with none due, kind %0d byte %02h", kind, out_byte));
        end else begin
          want = results_due.pop_front();
          if (kind !== want.kind)
            report($sformatf("kind %0d, want %0d", kind, want.kind));
          if (out_byte !== want.data)
            report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (last !== want.last)
            report($sformatf("last %0b, want %0b", last, want.last));
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

@@ tb/three_marker_stream_deframer_test.sv @@
// Top of the deframer test: clock, reset, stimulus, configuration phases and verdict.
module three_marker_stream_deframer_test
  import tmsd_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES = 7;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        link_closed;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic [2:0]  kind;
  logic        last;
  logic        wr_en;
  logic        wr_index;
  logic [12:0] wr_data;

  int errors;
  int pending;
  int cycles;
  int items_sent;
  int send_idle;
  int pop_idle;

  // Limits and idling per phase; zero limits and both ends of each range included
  int payload_tab [PHASES] = '{3, 4095, 0, 0, 1, 7, 1023};
  int hold_tab    [PHASES] = '{8, 8191, 1, 30, 0, 40, 2048};
  int count_tab   [PHASES] = '{20, 25, 6, 6, 6, 20, 25};
  int sidle_tab   [PHASES] = '{36, 36, 49, 49, 49, 49, 0};
  int pidle_tab   [PHASES] = '{49, 49, 36, 36, 36, 36, 0};

  three_marker_stream_deframer #(.BUFFER_BYTES(1024)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .link_closed(link_closed), .empty(empty), .pop(pop), .out_byte(out_byte),
    .kind(kind), .last(last), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  deframer_checker #(.BUFFER_BYTES(1024)) u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .link_closed(link_closed), .empty(empty), .pop(pop), .out_byte(out_byte),
    .kind(kind), .last(last), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random pops
  always @(negedge clk) begin
    if (!rst) pop <= ($urandom_range(99) >= pop_idle);
  end

  // Offer one item and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic closed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      data_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    link_closed <= closed;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_word(input string w);
    for (int i = 0; i < w.len(); i++) send_byte(w[i], 1'b0);
  endtask

  // One message: payload rich in marker letters, then mostly a marker
  task automatic send_frame();
    string letters;
    string w;
    int    plen;
    int    pick;
    letters = "ENXPCITD";
    plen = ($urandom_range(9) == 0) ? $urandom_range(45) : $urandom_range(10);
    for (int i = 0; i < plen; i++) begin
      pick = $urandom_range(9);
      if (pick < 4) send_byte(letters[$urandom_range(7)], 1'b0);
      else if (pick == 4) send_byte("E", 1'b0);
      else send_byte(8'($urandom_range(255)), 1'b0);
    end
    case ($urandom_range(2))
      0:       w = "END";
      1:       w = "EXPECT";
      default: w = "EXIT";
    endcase
    pick = $urandom_range(19);
    if (pick < 15) begin
      send_word(w);
    end else if (pick < 17) begin
      // broken marker
      send_word(w.substr(0, $urandom_range(w.len() - 2)));
      send_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick == 17) begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Stop sending and let the block go idle
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    int target;
    rst = 1'b1;
    push = 1'b0;
    data_byte = 8'h00;
    link_closed = 1'b0;
    pop = 1'b0;
    wr_en = 1'b0;
    wr_index = REG_PAYLOAD_LIMIT;
    wr_data = '0;
    items_sent = 0;
    send_idle = sidle_tab[0];
    pop_idle = pidle_tab[0];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items at reset limits: each marker, byte extremes,
    // mismatch keeping a new prefix, held bytes dropped by a closed link
    send_word("END");
    send_word("EXPECT");
    send_word("EXIT");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_word("EXPECE");
    send_word("EEND");
    send_word("EXIX");
    send_word("EX");
    send_byte(8'hFF, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      send_idle = sidle_tab[p];
      pop_idle = pidle_tab[p];
      write_reg(REG_PAYLOAD_LIMIT, {1'($urandom_range(1)), 12'(payload_tab[p])});
      write_reg(REG_HOLD_LIMIT, 13'(hold_tab[p]));
      if (p == 0) begin
        // payload past the limit, then overflow of the message
        for (int i = 0; i < 10; i++) send_byte(8'h41 + 8'(i), 1'b0);
      end
      target = items_sent + count_tab[p];
      while (items_sent < target) send_frame();
    end

    settle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
